// ===== rtl/masked_byte_pattern_scanner_defines.svh =====
// Assertion macros shared by the masked byte pattern scanner modules.
// Included by mbps_front and mbps_queue; no other dependencies.
`ifndef MASKED_BYTE_PATTERN_SCANNER_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MBPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbps_pkg.sv =====
// Package for the masked byte pattern scanner: constants, codes and the
// record types passed between the front end, the result queue and the back end.
package mbps_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_INDEX_W     = 2;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_SCAN    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Result kinds.
  localparam logic RESULT_MATCH = 1'b0;
  localparam logic RESULT_DONE  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIND_ALL       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_LIMIT    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS   = 2'd3;

  // Configuration register contents.
  typedef struct packed {
    logic [6:0]  pattern_length;
    logic        find_all;
    logic [15:0] match_limit;
    logic [31:0] base_address;
  } cfg_t;

  // Results caused by one scanned item: a match, a done report, or both.
  typedef struct packed {
    logic        has_match;
    logic        has_done;
    logic [31:0] address;
    logic [15:0] count;
  } rec_t;

  // Write side of the result queue.
  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

endpackage

// ===== rtl/mbps_if.sv =====
// Valid/ready channel interfaces of the masked byte pattern scanner.
// Standalone; carries the input item and result item fields.
interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] entry_index;
  logic [7:0] pattern_byte;
  logic       care_bit;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (
    output valid, cmd, entry_index, pattern_byte, care_bit, data_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, pattern_byte, care_bit, data_byte, last_byte,
    output ready
  );
endinterface

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] match_address;
  logic [15:0] match_count;
  logic        not_found;
  logic        last_of_run;

  modport source (
    output valid, result_kind, match_address, match_count, not_found, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, match_address, match_count, not_found, last_of_run,
    output ready
  );
endinterface

// ===== rtl/mbps_front.sv =====
// Front end: accepts items, keeps the pattern and byte window, compares the
// window in the next cycle, counts matches. Uses mbps_pkg, mbps_if, defines.
`include "masked_byte_pattern_scanner_defines.svh"

module mbps_front #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  mbps_in_if.sink           scan,
  input  mbps_pkg::cfg_t    cfg,
  input  logic              q_full,
  output mbps_pkg::push_t   push
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;
  localparam int WIN_W = 8 * MAX_PATTERN;

  logic [7:0]             pattern [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] care;
  logic [7:0]             window  [MAX_PATTERN];
  logic [31:0]            position;

  logic                   b_valid;
  logic                   b_restart;
  logic                   b_last;
  logic [31:0]            b_pos;

  logic [15:0]            found_count;
  logic                   stopped;

  mbps_pkg::cmd_t         cmd;
  logic                   take;
  logic                   b_fire;
  logic [IDX_W-1:0]       load_idx;
  logic                   load_ok;

  logic [CMP_W-1:0]       len_raw;
  logic [LEN_W-1:0]       len_eff;
  logic [LEN_W-1:0]       shift;
  logic [WIN_W-1:0]       rev_flat;
  logic [WIN_W-1:0]       aligned;
  logic [MAX_PATTERN-1:0] bad;
  logic                   hit;
  logic [31:0]            len_m1;
  logic                   full_window;
  logic                   stop_eff;
  logic                   test;
  logic [15:0]            cnt_inc;
  logic [15:0]            cnt_after;
  logic                   stop_after;
  logic [31:0]            address;

  // Handshake: hold off while the compare stage cannot hand its item on.
  assign cmd        = mbps_pkg::cmd_t'(scan.cmd);
  assign scan.ready = !(b_valid && q_full);
  assign take       = scan.valid && scan.ready;
  assign b_fire     = b_valid && !q_full;
  assign load_idx   = IDX_W'(scan.entry_index);
  assign load_ok    = 32'(scan.entry_index) < 32'(MAX_PATTERN);

  // Effective pattern length, clamped to 1..MAX_PATTERN.
  assign len_raw = CMP_W'(cfg.pattern_length);
  always_comb begin
    if (len_raw == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_raw > CMP_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = LEN_W'(len_raw);
    end
  end

  // Pattern bytes and window bytes hold payload only.
  always_ff @(posedge clk) begin
    if (take && cmd == mbps_pkg::CMD_LOAD && load_ok) begin
      pattern[load_idx] <= scan.pattern_byte;
    end
    if (take && cmd == mbps_pkg::CMD_SCAN) begin
      for (int i = MAX_PATTERN - 1; i > 0; i--) begin
        window[i] <= window[i-1];
      end
      window[0] <= scan.data_byte;
    end
  end

  // Care bits and byte position.
  always_ff @(posedge clk) begin
    if (rst) begin
      care     <= '1;
      position <= '0;
    end else if (take) begin
      unique case (cmd)
        mbps_pkg::CMD_LOAD: begin
          if (load_ok) begin
            care[load_idx] <= scan.care_bit;
          end
        end
        mbps_pkg::CMD_SCAN: begin
          position <= scan.last_byte ? '0 : position + 32'd1;
        end
        mbps_pkg::CMD_RESTART: begin
          position <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Compare stage register: scanned bytes and restarts move on in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (take && (cmd == mbps_pkg::CMD_SCAN || cmd == mbps_pkg::CMD_RESTART)) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_restart <= (cmd == mbps_pkg::CMD_RESTART);
      b_last    <= scan.last_byte;
      b_pos     <= position;
    end
  end

  // Line the window up with the pattern: byte j meets pattern entry j.
  assign shift = LEN_W'(MAX_PATTERN) - len_eff;
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      rev_flat[8*i +: 8] = window[MAX_PATTERN-1-i];
    end
  end
  assign aligned = rev_flat >> {shift, 3'b000};

  // Masked compare of every entry in parallel.
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      bad[j] = care[j] && (LEN_W'(j) < len_eff) && (pattern[j] != aligned[8*j +: 8]);
    end
  end
  assign hit = ~|bad;

  // Match decision, saturating count and stop flag.
  assign len_m1      = 32'(len_eff) - 32'd1;
  assign full_window = b_pos >= len_m1;
  assign stop_eff    = stopped || (cfg.find_all && cfg.match_limit == 16'd0);
  assign test        = !b_restart && !stop_eff && full_window && hit;
  assign cnt_inc     = (found_count != 16'hFFFF) ? found_count + 16'd1 : found_count;
  assign cnt_after   = test ? cnt_inc : found_count;
  assign stop_after  = test ? (!cfg.find_all || cnt_inc >= cfg.match_limit) : stop_eff;
  assign address     = cfg.base_address + b_pos - len_m1;

  assign push.valid         = b_fire && !b_restart && (test || b_last);
  assign push.rec.has_match = test;
  assign push.rec.has_done  = b_last;
  assign push.rec.address   = address;
  assign push.rec.count     = cnt_after;

  // Scan state; cleared by a restart and after the done report.
  always_ff @(posedge clk) begin
    if (rst) begin
      found_count <= '0;
      stopped     <= 1'b0;
    end else if (b_fire) begin
      if (b_restart || b_last) begin
        found_count <= '0;
        stopped     <= 1'b0;
      end else begin
        found_count <= cnt_after;
        stopped     <= stop_after;
      end
    end
  end

  `MBPS_ASSERT_NEXT(a_last_clears_pos, clk, rst, take && cmd == mbps_pkg::CMD_SCAN && scan.last_byte, position == 32'd0, "position not cleared after last byte")
  `MBPS_ASSERT_NEXT(a_restart_clears, clk, rst, b_fire && b_restart, found_count == 16'd0 && !stopped, "restart did not clear scan state")
  `MBPS_ASSERT_NOW(a_push_nonempty, clk, rst, push.valid, push.rec.has_match || push.rec.has_done, "empty result record pushed")

endmodule

// ===== rtl/mbps_queue.sv =====
// Result queue between the front end and the back end of the scanner.
// Holds one record per scanned item that caused results. Uses mbps_pkg.
`include "masked_byte_pattern_scanner_defines.svh"

module mbps_queue (
  input  logic            clk,
  input  logic            rst,
  input  mbps_pkg::push_t push,
  input  logic            pop,
  output logic            full,
  output logic            nonempty,
  output mbps_pkg::rec_t  head
);

  localparam int DEPTH = mbps_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mbps_pkg::rec_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push.valid) - CNT_W'(pop);
    end
  end

  `MBPS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "queue count above depth")
  `MBPS_ASSERT_NEXT(a_head_holds, clk, rst, nonempty && !pop, $stable(head), "queue head changed without pop")
  `MBPS_ASSERT_NEXT(a_pop_count, clk, rst, pop && !push.valid, count == $past(count) - CNT_W'(1), "pop did not lower count")

endmodule

// ===== rtl/mbps_back.sv =====
// Back end: turns each queued record into one or two result items on the
// output channel. Uses mbps_pkg and mbps_if.
module mbps_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           nonempty,
  input  mbps_pkg::rec_t head,
  output logic           pop,
  mbps_out_if.source     report
);

  logic second;
  logic emit_match;
  logic fire;

  // A record with both a match and a done report sends the match first.
  assign emit_match = head.has_match && !second;
  assign fire       = report.valid && report.ready;
  assign pop        = fire && !(emit_match && head.has_done);

  assign report.valid         = nonempty;
  assign report.result_kind   = emit_match ? mbps_pkg::RESULT_MATCH : mbps_pkg::RESULT_DONE;
  assign report.match_address = emit_match ? head.address : 32'd0;
  assign report.match_count   = head.count;
  assign report.not_found     = emit_match ? 1'b0 : (head.count == 16'd0);
  assign report.last_of_run   = emit_match ? !head.has_done : 1'b1;

  // Tracks that the match half of a two-result record has gone out.
  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (fire) begin
      second <= !pop;
    end
  end

endmodule

// ===== rtl/masked_byte_pattern_scanner.sv =====
// Masked byte pattern scanner. Takes one item per clock: loads, restarts and
// scanned bytes all go at full rate. A scanned byte is compared against the
// masked pattern in the cycle after it is taken, and its results reach the
// report channel through the result queue. The compare stage feeds a
// four-record result queue; a byte that causes both a match and a done report
// sends two result items on the report channel, so input is held off only when
// that queue is full and the compare stage is waiting on it. Configuration
// registers may be written only while no scanned byte is in flight.
// Depends on mbps_pkg, mbps_if, mbps_front, mbps_queue and mbps_back.
module masked_byte_pattern_scanner #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  mbps_in_if.sink                          scan,
  mbps_out_if.source                       report,
  input  logic                             cfg_write,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mbps_pkg::cfg_t  cfg;
  mbps_pkg::push_t push;
  mbps_pkg::rec_t  head;
  logic            q_full;
  logic            q_nonempty;
  logic            pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length <= 7'd1;
      cfg.find_all       <= 1'b0;
      cfg.match_limit    <= 16'hFFFF;
      cfg.base_address   <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mbps_pkg::CFG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[6:0];
        mbps_pkg::CFG_FIND_ALL:       cfg.find_all       <= cfg_data[0];
        mbps_pkg::CFG_MATCH_LIMIT:    cfg.match_limit    <= cfg_data[15:0];
        mbps_pkg::CFG_BASE_ADDRESS:   cfg.base_address   <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  mbps_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push)
  );

  mbps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (head)
  );

  mbps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (q_nonempty),
    .head     (head),
    .pop      (pop),
    .report   (report)
  );

endmodule

// ===== dv/tb.sv =====
// Testbench for masked_byte_pattern_scanner: a directed opening, then random item streams
// in several idling phases, with every report checked against a scoreboard's prediction.
// Depends on mbps_pkg, the mbps_in_if/mbps_out_if interfaces and the scanner RTL.
module tb;

  localparam int PATTERN_DEPTH = mbps_pkg::MAX_PATTERN_DEF;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS   = 180;

  typedef struct {
    mbps_pkg::cmd_t cmd;
    logic [5:0]     entry_index;
    logic [7:0]     pattern_byte;
    logic           care_bit;
    logic [7:0]     data_byte;
    logic           last_byte;
  } scan_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [15:0] count;
    logic        not_found;
    logic        last;
  } report_t;

  // Scoreboard: mirrors pattern, window and scan state, and queues the reports
  // that each accepted item should cause.
  class signature_scoreboard;
    mbps_pkg::cfg_t regs;
    logic [7:0]     pattern [PATTERN_DEPTH];
    bit             care [PATTERN_DEPTH];
    logic [7:0]     window [PATTERN_DEPTH];
    bit [31:0]      position;
    bit [15:0]      hits;
    bit             stopped;
    report_t        expected_reports [$];
    int             errors;

    function new();
      regs.pattern_length = 7'd1;
      regs.find_all       = 1'b0;
      regs.match_limit    = 16'hFFFF;
      regs.base_address   = 32'd0;
      foreach (pattern[i]) begin
        pattern[i] = 8'h00;
        care[i]    = 1'b1;
      end
      errors = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (window[i]) window[i] = 8'h00;
      position = 32'd0;
      hits     = 16'd0;
      stopped  = 1'b0;
    endfunction

    // Length register clamped to the range the compare actually uses.
    function int unsigned active_length();
      int unsigned len;
      len = regs.pattern_length;
      if (len < 1) len = 1;
      if (len > PATTERN_DEPTH) len = PATTERN_DEPTH;
      return len;
    endfunction

    function void set_reg(logic [mbps_pkg::CFG_INDEX_W-1:0] index,
                          logic [mbps_pkg::CFG_DATA_W-1:0] value);
      case (index)
        mbps_pkg::CFG_PATTERN_LENGTH: regs.pattern_length = value[6:0];
        mbps_pkg::CFG_FIND_ALL:       regs.find_all       = value[0];
        mbps_pkg::CFG_MATCH_LIMIT:    regs.match_limit    = value[15:0];
        mbps_pkg::CFG_BASE_ADDRESS:   regs.base_address   = value;
        default: ;
      endcase
    endfunction

    function void accept_item(scan_item_t it);
      int unsigned len;
      bit          hit;
      bit          has_match;
      bit          has_done;
      bit [31:0]   start;
      report_t     match_rep;
      report_t     done_rep;
      has_match = 1'b0;
      has_done  = 1'b0;
      case (it.cmd)
        mbps_pkg::CMD_LOAD: begin
          pattern[it.entry_index] = it.pattern_byte;
          care[it.entry_index]    = it.care_bit;
        end
        mbps_pkg::CMD_RESTART: clear_scan();
        mbps_pkg::CMD_SCAN: begin
          len = active_length();
          for (int i = PATTERN_DEPTH - 1; i > 0; i--) window[i] = window[i - 1];
          window[0] = it.data_byte;
          // A zero limit in find-all mode stops the scan before any test.
          if (!stopped && regs.find_all && regs.match_limit == 16'd0) stopped = 1'b1;
          // Entry 0 lines up with the oldest byte of the window.
          if (!stopped && position >= len - 1) begin
            hit = 1'b1;
            for (int j = 0; j < len; j++) begin
              if (care[j] && pattern[j] != window[len - 1 - j]) hit = 1'b0;
            end
            if (hit) begin
              start = position - (len - 1);
              if (hits != 16'hFFFF) hits++;
              match_rep = '{mbps_pkg::RESULT_MATCH, regs.base_address + start, hits,
                            1'b0, 1'b0};
              has_match = 1'b1;
              if (!regs.find_all || hits >= regs.match_limit) stopped = 1'b1;
            end
          end
          position++;
          if (it.last_byte) begin
            done_rep = '{mbps_pkg::RESULT_DONE, 32'd0, hits, hits == 16'd0, 1'b1};
            has_done = 1'b1;
            clear_scan();
          end
          if (has_match) begin
            match_rep.last = !has_done;
            expected_reports.push_back(match_rep);
          end
          if (has_done) expected_reports.push_back(done_rep);
        end
        default: ;
      endcase
    endfunction

    task note_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_report(report_t got);
      report_t want;
      if (expected_reports.size() == 0) begin
        note_mismatch($sformatf("report with none pending: kind %0d addr %h count %0d",
                                got.kind, got.address, got.count));
        return;
      end
      want = expected_reports.pop_front();
      if (got.kind !== want.kind || got.address !== want.address ||
          got.count !== want.count || got.not_found !== want.not_found ||
          got.last !== want.last) begin
        note_mismatch($sformatf(
          "got/want kind %0d/%0d addr %h/%h count %0d/%0d nf %0d/%0d last %0d/%0d",
          got.kind, want.kind, got.address, want.address, got.count, want.count,
          got.not_found, want.not_found, got.last, want.last));
      end
    endtask
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_write;
  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;

  signature_scoreboard sb;

  mbps_in_if  scan_ch ();
  mbps_out_if report_ch ();

  masked_byte_pattern_scanner DUT (
    .clk       (clk),
    .rst       (rst),
    .scan      (scan_ch),
    .report    (report_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Report side: check each accepted item, then pick the next ready value.
  initial begin
    report_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && report_ch.valid && report_ch.ready) begin
        sb.check_report('{report_ch.result_kind, report_ch.match_address,
                          report_ch.match_count, report_ch.not_found,
                          report_ch.last_of_run});
      end
      report_ch.ready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  // Item builders: fields a command does not use carry random values.
  function automatic scan_item_t random_item();
    scan_item_t it;
    it.cmd          = mbps_pkg::cmd_t'($urandom_range(3));
    it.entry_index  = 6'($urandom);
    it.pattern_byte = 8'($urandom);
    it.care_bit     = 1'($urandom);
    it.data_byte    = 8'($urandom);
    it.last_byte    = ($urandom_range(9) == 0);
    return it;
  endfunction

  function automatic scan_item_t load_item(logic [5:0] index, logic [7:0] value, logic care_on);
    scan_item_t it;
    it              = random_item();
    it.cmd          = mbps_pkg::CMD_LOAD;
    it.entry_index  = index;
    it.pattern_byte = value;
    it.care_bit     = care_on;
    return it;
  endfunction

  function automatic scan_item_t scan_item(logic [7:0] value, logic last);
    scan_item_t it;
    it           = random_item();
    it.cmd       = mbps_pkg::CMD_SCAN;
    it.data_byte = value;
    it.last_byte = last;
    return it;
  endfunction

  function automatic scan_item_t plain_item(mbps_pkg::cmd_t code);
    scan_item_t it;
    it     = random_item();
    it.cmd = code;
    return it;
  endfunction

  // Present one item after a random gap and hold it until it is taken.
  task automatic send(input scan_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      scan_ch.valid <= 1'b0;
      @(posedge clk);
    end
    scan_ch.valid        <= 1'b1;
    scan_ch.cmd          <= it.cmd;
    scan_ch.entry_index  <= it.entry_index;
    scan_ch.pattern_byte <= it.pattern_byte;
    scan_ch.care_bit     <= it.care_bit;
    scan_ch.data_byte    <= it.data_byte;
    scan_ch.last_byte    <= it.last_byte;
    @(posedge clk);
    while (!scan_ch.ready) @(posedge clk);
    sb.accept_item(it);
    items_sent++;
  endtask

  // Stop sending until every pending report is in, then let the pipeline settle.
  task automatic drain();
    scan_ch.valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges; only called while idle.
  task automatic write_config(input mbps_pkg::cfg_t c);
    logic [mbps_pkg::CFG_DATA_W-1:0]  vals [4];
    logic [mbps_pkg::CFG_INDEX_W-1:0] idxs [4];
    vals[0] = {25'd0, c.pattern_length};
    vals[1] = {31'd0, c.find_all};
    vals[2] = {16'd0, c.match_limit};
    vals[3] = c.base_address;
    idxs[0] = mbps_pkg::CFG_PATTERN_LENGTH;
    idxs[1] = mbps_pkg::CFG_FIND_ALL;
    idxs[2] = mbps_pkg::CFG_MATCH_LIMIT;
    idxs[3] = mbps_pkg::CFG_BASE_ADDRESS;
    for (int k = 0; k < 4; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= idxs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      sb.set_reg(idxs[k], vals[k]);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic directed_checks();
    // Length register 0 acts as 1; the base makes the first match address wrap.
    write_config('{7'd0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF});
    send(load_item(6'd0, 8'hFF, 1'b1));
    send(load_item(6'd63, 8'h00, 1'b0));
    send(plain_item(mbps_pkg::CMD_NONE));
    send(scan_item(8'h00, 1'b0));
    send(scan_item(8'hFF, 1'b0));
    // First-match mode ignores the rest of the scan.
    send(scan_item(8'hFF, 1'b0));
    send(scan_item(8'hFF, 1'b1));
    send(scan_item(8'h12, 1'b1));
    // A match on the last byte comes ahead of the done report.
    send(scan_item(8'hFF, 1'b1));
    // Load in the middle of a scan, then restart clears the stop flag.
    send(scan_item(8'h00, 1'b0));
    send(load_item(6'd0, 8'h00, 1'b1));
    send(scan_item(8'h00, 1'b0));
    send(plain_item(mbps_pkg::CMD_RESTART));
    send(scan_item(8'h00, 1'b1));
    drain();

    // Find-all mode with a zero limit reports no match, only a not-found done report.
    write_config('{7'd3, 1'b1, 16'd0, 32'd0});
    send(load_item(6'd1, 8'hA5, 1'b0));
    send(load_item(6'd2, 8'h5A, 1'b1));
    send(scan_item(8'h00, 1'b0));
    send(scan_item(8'h11, 1'b0));
    send(scan_item(8'h5A, 1'b1));
    drain();

    // Limit of two: the window must fill first, and the scan stops at the limit.
    write_config('{7'd3, 1'b1, 16'd2, 32'h8000_0000});
    send(scan_item(8'h5A, 1'b0));
    send(scan_item(8'h00, 1'b0));
    send(scan_item(8'h77, 1'b0));
    send(scan_item(8'h5A, 1'b0));
    send(scan_item(8'h00, 1'b0));
    send(scan_item(8'h00, 1'b0));
    send(scan_item(8'h5A, 1'b0));
    send(scan_item(8'h5A, 1'b1));
    drain();
  endtask

  // One scan built from copies of the current pattern with noise between them;
  // a broken run flips one bit in each copy.
  task automatic scan_run(input bit broken);
    logic [7:0]  bytes [$];
    int unsigned len;
    int unsigned copies;
    int unsigned bad;
    bit          ends;
    len = sb.active_length();
    if ($urandom_range(1)) send(plain_item(mbps_pkg::CMD_RESTART));
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 3))
        send(load_item(6'($urandom_range(len - 1)), 8'($urandom), $urandom_range(9) < 7));
    end
    copies = (len > 16) ? $urandom_range(1, 2) : $urandom_range(1, 3);
    repeat (copies) begin
      repeat ($urandom_range(0, (len < 8) ? 3 : len / 2)) bytes.push_back(8'($urandom));
      bad = broken ? $urandom_range(len - 1) : len;
      for (int j = 0; j < len; j++) begin
        bytes.push_back(sb.care[j] ? sb.pattern[j] : 8'($urandom));
        if (j == bad) bytes[$] ^= 8'h01 << $urandom_range(7);
      end
    end
    repeat ($urandom_range(2)) bytes.push_back(8'($urandom));
    ends = ($urandom_range(4) != 0);
    foreach (bytes[i]) send(scan_item(bytes[i], ends && (i == bytes.size() - 1)));
  endtask

  task automatic random_action();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) begin
      scan_run(1'b0);
    end else if (roll < 80) begin
      scan_run(1'b1);
    end else if (roll < 96) begin
      repeat ($urandom_range(1, 6)) send(random_item());
    end else begin
      drain();
    end
  endtask

  task automatic random_phases();
    mbps_pkg::cfg_t plan [8];
    int unsigned    phase_end;
    plan[0] = '{7'd1,   1'b1, 16'hFFFF, 32'h0000_0000};
    plan[1] = '{7'd64,  1'b1, 16'hFFFF, 32'hFFFF_FFFF};
    plan[2] = '{7'd127, 1'b0, 16'd1,    32'($urandom)};
    plan[3] = '{7'd4,   1'b1, 16'd3,    32'($urandom)};
    plan[4] = '{7'd2,   1'b1, 16'd1,    32'($urandom)};
    plan[5] = '{7'd8,   1'b0, 16'($urandom), 32'($urandom)};
    plan[6] = '{7'd3,   1'b1, 16'd0,    32'($urandom)};
    plan[7] = '{7'd5,   1'b1, 16'($urandom_range(1, 4)), 32'hFFFF_FFF0};
    // Fill the whole pattern store before any longer pattern is compared.
    for (int e = 0; e < PATTERN_DEPTH; e++)
      send(load_item(6'(e), 8'($urandom), $urandom_range(9) < 7));
    for (int p = 0; p < 8; p++) begin
      drain();
      write_config(plan[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 88;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 88;
        end
        default: begin
          send_idle_pct = 19;
          stall_pct     = 19;
        end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_action();
    end
  endtask

  initial begin
    sb                   = new();
    rst                  = 1'b1;
    cfg_write            = 1'b0;
    cfg_index            = mbps_pkg::CFG_PATTERN_LENGTH;
    cfg_data             = '0;
    scan_ch.valid        = 1'b0;
    scan_ch.cmd          = mbps_pkg::CMD_NONE;
    scan_ch.entry_index  = '0;
    scan_ch.pattern_byte = '0;
    scan_ch.care_bit     = 1'b0;
    scan_ch.data_byte    = '0;
    scan_ch.last_byte    = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    directed_checks();
    random_phases();
    drain();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mbps_pkg.sv
rtl/mbps_if.sv
rtl/mbps_front.sv
rtl/mbps_queue.sv
rtl/mbps_back.sv
rtl/masked_byte_pattern_scanner.sv
dv/tb.sv
